// File: design/tgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tgr_pkg;

	localparam int XY_W       = 12;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 7;
	localparam int MS_W       = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [1:0] {
		ZONE_MIDDLE = 2'd0,
		ZONE_LEFT   = 2'd1,
		ZONE_RIGHT  = 2'd2
	} zone_t;

	typedef enum logic [2:0] {
		ACT_NONE        = 3'd0,
		ACT_SET_BRIGHT  = 3'd1,
		ACT_SET_VOLUME  = 3'd2,
		ACT_CONFIG_MODE = 3'd3,
		ACT_LISTEN      = 3'd4,
		ACT_TOGGLE_CHAT = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_LIMIT  = 3'd0,
		CFG_RIGHT_LIMIT = 3'd1,
		CFG_MOVE_THRESH = 3'd2,
		CFG_LONG_PRESS  = 3'd3,
		CFG_DOUBLE_TAP  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [XY_W-1:0] left_zone_limit;
		logic [XY_W-1:0] right_zone_limit;
		logic [XY_W-1:0] move_threshold;
		logic [MS_W-1:0] long_press_ms;
		logic [MS_W-1:0] double_tap_ms;
	} cfg_t;

	localparam logic [XY_W-1:0] LEFT_LIMIT_RST  = 12'd60;
	localparam logic [XY_W-1:0] RIGHT_LIMIT_RST = 12'd180;
	localparam logic [XY_W-1:0] MOVE_THRESH_RST = 12'd10;
	localparam logic [MS_W-1:0] LONG_PRESS_RST  = 16'd3000;
	localparam logic [MS_W-1:0] DOUBLE_TAP_RST  = 16'd250;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
	localparam logic [LEVEL_W-1:0] BRIGHT_MIN = 7'd1;
	localparam logic [LEVEL_W-1:0] VOLUME_MIN = 7'd0;

	// floor(m/5) == (m * 13108) >> 16 for every 12-bit m
	localparam int DIV5_RECIP = 13108;
	localparam int DIV5_SHIFT = 16;
	localparam int QUOT_W     = 10;

endpackage

`default_nettype wire

// File: design/tgr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tgr_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tgr_pkg::cfg_t                        cfg
);

	tgr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_zone_limit  <= tgr_pkg::LEFT_LIMIT_RST;
			cfg_q.right_zone_limit <= tgr_pkg::RIGHT_LIMIT_RST;
			cfg_q.move_threshold   <= tgr_pkg::MOVE_THRESH_RST;
			cfg_q.long_press_ms    <= tgr_pkg::LONG_PRESS_RST;
			cfg_q.double_tap_ms    <= tgr_pkg::DOUBLE_TAP_RST;
		end else if (cfg_we) begin
			unique case (tgr_pkg::cfg_idx_t'(cfg_index))
				tgr_pkg::CFG_LEFT_LIMIT:  cfg_q.left_zone_limit  <= cfg_data[tgr_pkg::XY_W-1:0];
				tgr_pkg::CFG_RIGHT_LIMIT: cfg_q.right_zone_limit <= cfg_data[tgr_pkg::XY_W-1:0];
				tgr_pkg::CFG_MOVE_THRESH: cfg_q.move_threshold   <= cfg_data[tgr_pkg::XY_W-1:0];
				tgr_pkg::CFG_LONG_PRESS:  cfg_q.long_press_ms    <= cfg_data[tgr_pkg::MS_W-1:0];
				tgr_pkg::CFG_DOUBLE_TAP:  cfg_q.double_tap_ms    <= cfg_data[tgr_pkg::MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: design/tgr_slide_level.sv
`timescale 1ns / 1ps
`default_nettype none

// New level = cur_level - dy/5 (toward zero), clamped to min_level..LEVEL_MAX.
module tgr_slide_level (
	input  wire logic [tgr_pkg::LEVEL_W-1:0] cur_level,
	input  wire logic [tgr_pkg::XY_W-1:0]    dy_mag,
	input  wire logic                        dy_neg,
	input  wire logic [tgr_pkg::LEVEL_W-1:0] min_level,
	output logic      [tgr_pkg::LEVEL_W-1:0] level
);

	localparam int PROD_W = tgr_pkg::XY_W + 15;
	localparam int RAW_W  = tgr_pkg::XY_W + 1;

	logic [PROD_W-1:0]               prod;
	logic [tgr_pkg::QUOT_W-1:0]      quot;
	logic signed [RAW_W-1:0]         raw;
	logic signed [RAW_W-1:0]         lo_s;
	logic signed [RAW_W-1:0]         hi_s;

	always_comb begin
		prod = PROD_W'(dy_mag) * PROD_W'(tgr_pkg::DIV5_RECIP);
		quot = prod[tgr_pkg::DIV5_SHIFT +: tgr_pkg::QUOT_W];
		// moving down (negative dy) raises the level
		if (dy_neg)
			raw = $signed(RAW_W'(cur_level)) + $signed(RAW_W'(quot));
		else
			raw = $signed(RAW_W'(cur_level)) - $signed(RAW_W'(quot));
		lo_s = $signed(RAW_W'(min_level));
		hi_s = $signed(RAW_W'(tgr_pkg::LEVEL_MAX));
		if (raw < lo_s)
			level = min_level;
		else if (raw > hi_s)
			level = tgr_pkg::LEVEL_MAX;
		else
			level = raw[tgr_pkg::LEVEL_W-1:0];
	end

endmodule

`default_nettype wire

// File: design/touch_gesture_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                                            | Dir | Handshake
// --------+----------------------------------------------------+-----+----------------
// cfg     | cfg_index, cfg_data                                | in  | cfg_we, no wait
// in      | touched, pos_x, pos_y, now_ms, cur_brightness,     | in  | in_valid/in_ready
//         | cur_volume                                         |     |
// out     | action, level                                      | out | out_valid/out_ready
//
// One sample per clock sustained while out_ready stays high; an accepted sample
// passes the input register, then the result register, before out_valid rises.
// The gesture state is
// updated in the same cycle the result register loads, so a sample sees all
// earlier ones. Reset clears the gesture state and loads the default configuration.
// With out_ready low the result holds, one more sample waits in the input
// register, then in_ready drops.
module touch_gesture_recognizer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            touched,
	input  wire logic [tgr_pkg::XY_W-1:0]        pos_x,
	input  wire logic [tgr_pkg::XY_W-1:0]        pos_y,
	input  wire logic [tgr_pkg::TIME_W-1:0]      now_ms,
	input  wire logic [tgr_pkg::LEVEL_W-1:0]     cur_brightness,
	input  wire logic [tgr_pkg::LEVEL_W-1:0]     cur_volume,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [2:0]                           action,
	output logic [tgr_pkg::LEVEL_W-1:0]          level
);

	localparam int DY_W = tgr_pkg::XY_W + 1;

	tgr_pkg::cfg_t cfg;

	// input stage
	logic                            valid_s1;
	logic                            touched_s1;
	logic [tgr_pkg::XY_W-1:0]        pos_x_s1;
	logic [tgr_pkg::XY_W-1:0]        pos_y_s1;
	logic [tgr_pkg::TIME_W-1:0]      now_s1;
	logic [tgr_pkg::LEVEL_W-1:0]     bright_s1;
	logic [tgr_pkg::LEVEL_W-1:0]     volume_s1;

	// gesture state
	logic                            press_active_q, press_active_d;
	logic [tgr_pkg::TIME_W-1:0]      press_start_q, press_start_d;
	logic [tgr_pkg::TIME_W-1:0]      last_tap_q, last_tap_d;
	logic [tgr_pkg::XY_W-1:0]        anchor_y_q, anchor_y_d;
	logic                            slide_seen_q, slide_seen_d;
	tgr_pkg::zone_t                  zone_q, zone_d;

	// result stage
	logic                            out_valid_q;
	tgr_pkg::action_t                action_q, action_d;
	logic [tgr_pkg::LEVEL_W-1:0]     level_q, level_d;

	logic                            advance;
	logic signed [DY_W-1:0]          dy;
	logic [DY_W-1:0]                 dy_abs;
	logic [tgr_pkg::XY_W-1:0]        dy_mag;
	logic [tgr_pkg::TIME_W-1:0]      held;
	logic [tgr_pkg::TIME_W-1:0]      since_tap;
	logic [tgr_pkg::LEVEL_W-1:0]     slide_cur;
	logic [tgr_pkg::LEVEL_W-1:0]     slide_min;
	logic [tgr_pkg::LEVEL_W-1:0]     slide_level;

	tgr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			touched_s1 <= touched;
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			now_s1     <= now_ms;
			bright_s1  <= cur_brightness;
			volume_s1  <= cur_volume;
		end
	end

	always_comb begin
		dy        = $signed(DY_W'(pos_y_s1)) - $signed(DY_W'(anchor_y_q));
		dy_abs    = dy[DY_W-1] ? DY_W'(-dy) : DY_W'(dy);
		dy_mag    = dy_abs[tgr_pkg::XY_W-1:0];
		held      = now_s1 - press_start_q;
		since_tap = now_s1 - last_tap_q;
		slide_cur = (zone_q == tgr_pkg::ZONE_LEFT) ? bright_s1 : volume_s1;
		slide_min = (zone_q == tgr_pkg::ZONE_LEFT) ? tgr_pkg::BRIGHT_MIN : tgr_pkg::VOLUME_MIN;
	end

	tgr_slide_level u_slide (
		.cur_level (slide_cur),
		.dy_mag    (dy_mag),
		.dy_neg    (dy[DY_W-1]),
		.min_level (slide_min),
		.level     (slide_level)
	);

	always_comb begin
		press_active_d = press_active_q;
		press_start_d  = press_start_q;
		last_tap_d     = last_tap_q;
		anchor_y_d     = anchor_y_q;
		slide_seen_d   = slide_seen_q;
		zone_d         = zone_q;
		action_d       = tgr_pkg::ACT_NONE;
		level_d        = '0;

		if (touched_s1) begin
			if (!press_active_q) begin
				press_active_d = 1'b1;
				press_start_d  = now_s1;
				anchor_y_d     = pos_y_s1;
				slide_seen_d   = 1'b0;
				if (pos_x_s1 < cfg.left_zone_limit)
					zone_d = tgr_pkg::ZONE_LEFT;
				else if (pos_x_s1 > cfg.right_zone_limit)
					zone_d = tgr_pkg::ZONE_RIGHT;
				else
					zone_d = tgr_pkg::ZONE_MIDDLE;
			end else if (dy_mag > cfg.move_threshold) begin
				// middle zone only re-anchors
				case (zone_q)
					tgr_pkg::ZONE_LEFT: begin
						slide_seen_d = 1'b1;
						action_d     = tgr_pkg::ACT_SET_BRIGHT;
						level_d      = slide_level;
					end
					tgr_pkg::ZONE_RIGHT: begin
						slide_seen_d = 1'b1;
						action_d     = tgr_pkg::ACT_SET_VOLUME;
						level_d      = slide_level;
					end
					default: ;
				endcase
				anchor_y_d = pos_y_s1;
			end
		end else if (press_active_q) begin
			press_active_d = 1'b0;
			if (!slide_seen_q) begin
				if (held > tgr_pkg::TIME_W'(cfg.long_press_ms)) begin
					action_d = tgr_pkg::ACT_CONFIG_MODE;
				end else if (since_tap < tgr_pkg::TIME_W'(cfg.double_tap_ms)) begin
					action_d   = tgr_pkg::ACT_LISTEN;
					last_tap_d = '0;
				end else begin
					action_d   = tgr_pkg::ACT_TOGGLE_CHAT;
					last_tap_d = now_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_active_q <= 1'b0;
			press_start_q  <= '0;
			last_tap_q     <= '0;
			anchor_y_q     <= '0;
			slide_seen_q   <= 1'b0;
			zone_q         <= tgr_pkg::ZONE_MIDDLE;
		end else if (advance) begin
			press_active_q <= press_active_d;
			press_start_q  <= press_start_d;
			last_tap_q     <= last_tap_d;
			anchor_y_q     <= anchor_y_d;
			slide_seen_q   <= slide_seen_d;
			zone_q         <= zone_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= action_d;
			level_q  <= level_d;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign level     = level_q;

endmodule

`default_nettype wire

// File: design/tgr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tgr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [2:0]                      action,
	input wire logic [tgr_pkg::LEVEL_W-1:0]     level
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(level))
		else $error("result changed while stalled");

	// a transaction taken in while the output is free shows up after the input and result registers
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |=> ##1 out_valid)
		else $error("accepted sample produced no result");

	a_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != tgr_pkg::ACT_SET_BRIGHT && action != tgr_pkg::ACT_SET_VOLUME
		|-> level == '0)
		else $error("level nonzero for non-slide action");

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tgr_pkg::ACT_SET_BRIGHT
		|-> level >= tgr_pkg::BRIGHT_MIN && level <= tgr_pkg::LEVEL_MAX)
		else $error("brightness out of range");

	a_volume_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == tgr_pkg::ACT_SET_VOLUME |-> level <= tgr_pkg::LEVEL_MAX)
		else $error("volume out of range");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.action    (action),
	.level     (level)
);

`default_nettype wire
